// File: rtl/core/sliding_median_abs_deviation_cost_assert.svh
// assertion macros for the sliding median block
`ifndef SLIDING_MEDIAN_ABS_DEVIATION_COST_ASSERT_SVH
`define SLIDING_MEDIAN_ABS_DEVIATION_COST_ASSERT_SVH
`define SMAD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SMAD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: rtl/core/smad_pkg.sv
// ----------------------------------------------------------------------------
// smad_pkg
// types and constants shared by the sliding median cost block
// ----------------------------------------------------------------------------
package smad_pkg;
    localparam int LEN_BITS    = 7;
    localparam int SAMPLE_BITS = 32;
    localparam int MEDIAN_BITS = 32;
    localparam int COST_BITS   = 38;
    localparam logic [LEN_BITS-1:0] LEN_RESET = 7'd16;

    typedef struct packed {
        logic [31:0] sample;
        logic        restart;
    } in_beat_t;

    typedef struct packed {
        logic [MEDIAN_BITS-1:0] median;
        logic [COST_BITS-1:0]   cost;
    } out_beat_t;

    // per-cycle command broadcast to all cells
    typedef struct packed {
        logic ins;
        logic del;
        logic clr;
    } cell_cmd_t;
endpackage

// File: rtl/core/smad_cell.sv
// ----------------------------------------------------------------------------
// smad_cell
// one slot of the sorted chain; shifts toward neighbors on insert and delete
// ----------------------------------------------------------------------------
module smad_cell #(
    parameter int SAMPLE_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  smad_pkg::cell_cmd_t    cmd,
    input  logic [SAMPLE_BITS-1:0] ins_val,
    input  logic [SAMPLE_BITS-1:0] del_val,
    input  logic [SAMPLE_BITS-1:0] left_val,
    input  logic                   left_valid,
    input  logic                   left_gt_ins,
    input  logic                   left_del_hit,
    input  logic [SAMPLE_BITS-1:0] right_val,
    input  logic                   right_valid,
    output logic [SAMPLE_BITS-1:0] val,
    output logic                   valid,
    output logic                   gt_ins,
    output logic                   del_hit
);
    import smad_pkg::*;

    logic [SAMPLE_BITS-1:0] val_reg, val_next;
    logic                   valid_reg, valid_next;

    // at or past the first entry equal to the deleted value
    assign del_hit = left_del_hit || (valid_reg && val_reg == del_val);
    // strictly greater than the new value, or empty
    assign gt_ins  = !valid_reg || val_reg > ins_val;

    always_comb
    begin
        val_next   = val_reg;
        valid_next = valid_reg;
        if (cmd.clr)
        begin
            valid_next = 1'b0;
        end
        else if (cmd.del && cmd.ins)
        begin
            // remove then insert; only occupied cells change
            if (valid_reg && del_hit)
            begin
                if (right_valid && !(right_val > ins_val))
                begin
                    val_next = right_val;
                end
                else if (left_del_hit)
                begin
                    val_next = (val_reg > ins_val) ? val_reg : ins_val;
                end
                else
                begin
                    val_next = (left_valid && left_val > ins_val) ? left_val : ins_val;
                end
            end
            else if (valid_reg && gt_ins)
            begin
                val_next = (left_gt_ins && left_valid) ? left_val : ins_val;
            end
        end
        else if (cmd.ins)
        begin
            if (gt_ins)
            begin
                val_next   = left_gt_ins ? left_val : ins_val;
                valid_next = left_gt_ins ? left_valid : 1'b1;
            end
        end
        else if (cmd.del)
        begin
            if (del_hit)
            begin
                val_next   = right_val;
                valid_next = right_valid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val   = val_reg;
    assign valid = valid_reg;
endmodule

// File: rtl/core/smad_chain.sv
// ----------------------------------------------------------------------------
// smad_chain
// row of sorted cells
// ----------------------------------------------------------------------------
module smad_chain #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  smad_pkg::cell_cmd_t                    cmd,
    input  logic [SAMPLE_BITS-1:0]                 ins_val,
    input  logic [SAMPLE_BITS-1:0]                 del_val,
    output logic [WINDOW_MAX-1:0][SAMPLE_BITS-1:0] vals
);
    import smad_pkg::*;

    logic [WINDOW_MAX:0][SAMPLE_BITS-1:0] lv;
    logic [WINDOW_MAX:0]                  lvalid, lgt, lhit;
    logic [WINDOW_MAX:0][SAMPLE_BITS-1:0] rv;
    logic [WINDOW_MAX:0]                  rvalid;

    assign lv[0]     = '0;
    assign lvalid[0] = 1'b0;
    assign lgt[0]    = 1'b0;
    assign lhit[0]   = 1'b0;
    assign rv[WINDOW_MAX]     = '0;
    assign rvalid[WINDOW_MAX] = 1'b0;

    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        logic [SAMPLE_BITS-1:0] v;
        logic                   vd;
        smad_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .ins_val     (ins_val),
            .del_val     (del_val),
            .left_val    (lv[i]),
            .left_valid  (lvalid[i]),
            .left_gt_ins (lgt[i]),
            .left_del_hit(lhit[i]),
            .right_val   (rv[i+1]),
            .right_valid (rvalid[i+1]),
            .val         (v),
            .valid       (vd),
            .gt_ins      (lgt[i+1]),
            .del_hit     (lhit[i+1])
        );
        assign lv[i+1]     = v;
        assign lvalid[i+1] = vd;
        assign rv[i]       = v;
        assign rvalid[i]   = vd;
        assign vals[i]     = v;
    end
endmodule

// File: rtl/core/sliding_median_abs_deviation_cost.sv
// ----------------------------------------------------------------------------
// sliding_median_abs_deviation_cost
// sliding window median and sum of absolute deviations
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  in        in   in_valid/ready   smad_pkg::in_beat_t
//  out       out  out_valid/ready  smad_pkg::out_beat_t
//  cfg       in   cfg_we           window_len (7 bits)
// a beat reads the ring and updates the sorted cell row; a beat that
// completes the window then takes the median and sums one cell a cycle,
// while a beat that only fills returns to idle without a median
// reset empties the window and sets window_len to 16
// a finished result waits while the output register is full, holding off input
// ----------------------------------------------------------------------------
module sliding_median_abs_deviation_cost #(
    parameter int WINDOW_MAX  = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  smad_pkg::in_beat_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output smad_pkg::out_beat_t out_data,
    input  logic                cfg_we,
    input  logic [6:0]          cfg_data
);
    import smad_pkg::*;

    localparam int IDX_BITS = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_BITS = $clog2(WINDOW_MAX + 1);

    typedef enum logic [2:0] {S_IDLE, S_RD, S_UPD, S_MED, S_SUM, S_OUT} state_t;

    state_t                 state_reg;
    logic [LEN_BITS-1:0]    len_reg;
    logic [CNT_BITS-1:0]    fill_reg, len_eff;
    logic [IDX_BITS-1:0]    old_reg, wpos, idx_reg, old_now;
    logic [SAMPLE_BITS-1:0] ring [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] rd_reg, smp_reg;
    logic [SAMPLE_BITS:0]   med_reg;
    logic [COST_BITS-1:0]   cost_reg;
    logic                   full_reg;
    cell_cmd_t              cmd;
    logic [WINDOW_MAX-1:0][SAMPLE_BITS-1:0] vals;
    logic [CNT_BITS-1:0]    fill_now;
    logic [SAMPLE_BITS:0]   dv;

    always_comb
    begin
        if (len_reg == '0)
            len_eff = CNT_BITS'(1);
        else if (32'(len_reg) > WINDOW_MAX)
            len_eff = CNT_BITS'(WINDOW_MAX);
        else
            len_eff = CNT_BITS'(len_reg);
    end

    assign in_ready = (state_reg == S_IDLE) && !cfg_we;
    assign fill_now = (in_data.restart || fill_reg > len_eff) ? '0 : fill_reg;
    assign old_now  = (fill_now == '0) ? '0 : old_reg;

    // ring write slot
    always_comb
    begin
        logic [CNT_BITS:0] p;
        p = {1'b0, CNT_BITS'(old_now)} + {1'b0, fill_now};
        if (p >= {1'b0, len_eff})
            p = p - {1'b0, len_eff};
        wpos = (fill_now == len_eff) ? old_now : p[IDX_BITS-1:0];
    end

    always_comb
    begin
        cmd.clr = cfg_we || (in_valid && in_ready && fill_now == '0);
        cmd.ins = (state_reg == S_UPD);
        cmd.del = (state_reg == S_UPD) && full_reg;
    end

    smad_chain #(.WINDOW_MAX(WINDOW_MAX), .SAMPLE_BITS(SAMPLE_BITS)) u_chain (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .ins_val(smp_reg),
        .del_val(rd_reg),
        .vals   (vals)
    );

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            rd_reg <= ring[wpos];
            ring[wpos] <= in_data.sample[SAMPLE_BITS-1:0];
        end
    end

    assign dv = ({1'b0, vals[idx_reg]} >= med_reg) ? ({1'b0, vals[idx_reg]} - med_reg)
                                                    : (med_reg - {1'b0, vals[idx_reg]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            len_reg   <= LEN_RESET;
            fill_reg  <= '0;
            old_reg   <= '0;
            out_valid <= 1'b0;
            full_reg  <= 1'b0;
            idx_reg   <= '0;
            smp_reg   <= '0;
            med_reg   <= '0;
            cost_reg  <= '0;
            out_data  <= '0;
        end
        else
        begin
            if (state_reg == S_OUT && (!out_valid || out_ready))
                out_valid <= 1'b1;
            else if (out_valid && out_ready)
                out_valid <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cfg_we)
                    begin
                        len_reg  <= cfg_data;
                        fill_reg <= '0;
                        old_reg  <= '0;
                    end
                    else if (in_valid && in_ready)
                    begin
                        smp_reg  <= in_data.sample[SAMPLE_BITS-1:0];
                        full_reg <= (fill_now == len_eff);
                        if (fill_now == len_eff)
                        begin
                            old_reg  <= (32'(old_reg) + 1 >= 32'(len_eff))
                                      ? '0 : old_reg + IDX_BITS'(1);
                            fill_reg <= fill_now;
                        end
                        else
                        begin
                            old_reg  <= (fill_now == '0) ? '0 : old_reg;
                            fill_reg <= fill_now + CNT_BITS'(1);
                        end
                        state_reg <= S_RD;
                    end
                end
                S_RD:  state_reg <= S_UPD;
                S_UPD: state_reg <= S_MED;
                S_MED:
                begin
                    if (fill_reg != len_eff)
                        state_reg <= S_IDLE;
                    else
                    begin
                        if (len_eff[0])
                            med_reg <= {1'b0, vals[IDX_BITS'(len_eff >> 1)]};
                        else
                            med_reg <= ({1'b0, vals[IDX_BITS'((len_eff >> 1) - 1)]}
                                      + {1'b0, vals[IDX_BITS'(len_eff >> 1)]}) >> 1;
                        idx_reg   <= '0;
                        cost_reg  <= '0;
                        state_reg <= S_SUM;
                    end
                end
                S_SUM:
                begin
                    cost_reg <= cost_reg + COST_BITS'(dv);
                    if (32'(idx_reg) + 1 >= 32'(len_eff))
                        state_reg <= S_OUT;
                    else
                        idx_reg <= idx_reg + IDX_BITS'(1);
                end
                S_OUT:
                begin
                    if (!out_valid || out_ready)
                    begin
                        out_data.median <= MEDIAN_BITS'(med_reg);
                        out_data.cost   <= cost_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// File: rtl/core/smad_checker.sv
// ----------------------------------------------------------------------------
// smad_checker
// port-level checks for the sliding median block
// ----------------------------------------------------------------------------
`include "sliding_median_abs_deviation_cost_assert.svh"
module smad_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input smad_pkg::out_beat_t out_data,
    input logic                cfg_we
);
    import smad_pkg::*;

    `SMAD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
    `SMAD_ASSERT_IMPL(a_cfg_block, cfg_we, !in_ready)
    `SMAD_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready)
endmodule

bind sliding_median_abs_deviation_cost smad_checker u_smad_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we)
);
